// ===== sv/pidcfd_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// pidcfd_pkg
// Shared types, register indexes and saturation helpers for the PID
// controller with filtered derivative.
// -----------------------------------------------------------------------------
package pidcfd_pkg;

	localparam int FRAC_BITS_DEFAULT = 16;
	localparam int COEF_BITS         = 16;
	localparam int DATA_W            = 32;
	localparam int CFG_IDX_W         = 3;
	localparam int DEADBAND_W        = 31;
	localparam int COEF_W            = 17;
	localparam int MUL_W             = DATA_W + 1;
	localparam int PROD_W            = 2 * MUL_W;
	localparam int ACC_W             = DATA_W + 2;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

	localparam cfg_idx_t CFG_KP       = 3'd0;
	localparam cfg_idx_t CFG_KI       = 3'd1;
	localparam cfg_idx_t CFG_KD       = 3'd2;
	localparam cfg_idx_t CFG_KFF      = 3'd3;
	localparam cfg_idx_t CFG_OUT_MAX  = 3'd4;
	localparam cfg_idx_t CFG_OUT_MIN  = 3'd5;
	localparam cfg_idx_t CFG_DEADBAND = 3'd6;
	localparam cfg_idx_t CFG_COEF     = 3'd7;

	localparam data_t               DATA_MAX   = 32'sh7FFF_FFFF;
	localparam data_t               DATA_MIN   = 32'sh8000_0000;
	localparam logic [COEF_W-1:0]   COEF_ONE   = 17'd65536;
	localparam logic [COEF_W-1:0]   COEF_RESET = 17'd6554;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_DB,
		ST_MP,
		ST_MI,
		ST_MC1,
		ST_MC2,
		ST_MFF,
		ST_MD,
		ST_DW,
		ST_SUM,
		ST_FIN
	} state_t;

	function automatic data_t sat32(input logic signed [PROD_W-1:0] v);
		if (v > PROD_W'(DATA_MAX))
			return DATA_MAX;
		else if (v < PROD_W'(DATA_MIN))
			return DATA_MIN;
		else
			return DATA_W'(v);
	endfunction

	function automatic data_t clamp_ordered(input data_t v, input data_t hi, input data_t lo);
		if (v > hi)
			return hi;
		else if (v < lo)
			return lo;
		else
			return v;
	endfunction

endpackage
`default_nettype wire

// ===== sv/pidcfd_step_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// pidcfd_step_if
// Controller step request: target, feedback and enable.
// -----------------------------------------------------------------------------
interface pidcfd_step_if;
	import pidcfd_pkg::*;

	logic  valid;
	logic  ready;
	data_t target;
	data_t feedback;
	logic  enabled;

	modport source (output valid, output target, output feedback, output enabled,
		input ready);
	modport sink (input valid, input target, input feedback, input enabled,
		output ready);
endinterface
`default_nettype wire

// ===== sv/pidcfd_result_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// pidcfd_result_if
// Controller result request: clamped drive and error after deadband.
// -----------------------------------------------------------------------------
interface pidcfd_result_if;
	import pidcfd_pkg::*;

	logic  valid;
	logic  ready;
	data_t drive;
	data_t error_now;

	modport source (output valid, output drive, output error_now, input ready);
	modport sink (input valid, input drive, input error_now, output ready);
endinterface
`default_nettype wire

// ===== sv/pidcfd_cfg_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// pidcfd_cfg_if
// Register write request: register index and write data.
// -----------------------------------------------------------------------------
interface pidcfd_cfg_if;
	import pidcfd_pkg::*;

	logic     valid;
	logic     ready;
	cfg_idx_t index;
	data_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/pid_controller_filtered_derivative.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// pid_controller_filtered_derivative
// Positional PID step with deadband, clamped integral, low-pass filtered
// derivative and target feedforward, signed fixed point.
// -----------------------------------------------------------------------------
// Usage:
//   step   : one request per controller step (target, feedback, enabled).
//   result : one request per step (drive, error_now), held in an output
//            register until taken.
//   cfg    : register writes, always ready; write only while the block idles.
// Timing: an enabled step runs through ERR, DB, MP, MI, MC1, MC2, MFF, MD,
//   DW, SUM and FIN; the next step is taken only back in IDLE. All
//   six products go through one 33x33 multiplier, one per cycle, under a
//   sequencer. A disabled step goes from IDLE straight to FIN.
// Stall: a new step is taken while a result still waits in the output
//   register; its own result is held in the last state until that register
//   frees up.
// Reset: gains clear, output limits go to full range, filter weight to about
//   0.1, and integral, filtered slope and previous error clear to zero.
// -----------------------------------------------------------------------------
module pid_controller_filtered_derivative #(
	parameter int FRAC_BITS = pidcfd_pkg::FRAC_BITS_DEFAULT
) (
	input  wire            clk,
	input  wire            arst_n,
	pidcfd_step_if.sink    step,
	pidcfd_result_if.source result,
	pidcfd_cfg_if.sink     cfg
);
	import pidcfd_pkg::*;

	data_t                     kp_q, ki_q, kd_q, kff_q, out_max_q, out_min_q;
	logic [DEADBAND_W-1:0]     deadband_q;
	logic [COEF_W-1:0]         coef_q;

	state_t                    state_q, state_d;

	data_t                     tgt_q, fb_q, err_q, raw_q, half_q, imin_q;
	data_t                     int_q, filt_q, prev_q, slope_q, drive_q;
	logic [COEF_W-1:0]         cw_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic                      prod_frac_q;

	logic                      out_vld_q;
	data_t                     out_drive_q, out_err_q;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic                      mul_frac;
	logic signed [PROD_W-1:0]  prod_sh;
	data_t                     term;
	logic [DATA_W-1:0]         abs_err;
	logic signed [DATA_W:0]    span;
	data_t                     half_c;
	logic                      accept, out_load;

	assign accept   = step.valid && step.ready;
	assign out_load = (state_q == ST_FIN) && (!out_vld_q || result.ready);

	assign prod_sh = prod_frac_q ? (prod_q >>> FRAC_BITS) : (prod_q >>> COEF_BITS);
	assign term    = sat32(prod_sh);
	assign abs_err = err_q[DATA_W-1] ? DATA_W'(-err_q) : DATA_W'(err_q);
	assign span    = (DATA_W+1)'(out_max_q) - (DATA_W+1)'(out_min_q);
	assign half_c  = DATA_W'(span >>> 1);

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q       <= '0;
			ki_q       <= '0;
			kd_q       <= '0;
			kff_q      <= '0;
			out_max_q  <= DATA_MAX;
			out_min_q  <= DATA_MIN;
			deadband_q <= '0;
			coef_q     <= COEF_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_KP:       kp_q       <= cfg.data;
				CFG_KI:       ki_q       <= cfg.data;
				CFG_KD:       kd_q       <= cfg.data;
				CFG_KFF:      kff_q      <= cfg.data;
				CFG_OUT_MAX:  out_max_q  <= cfg.data;
				CFG_OUT_MIN:  out_min_q  <= cfg.data;
				CFG_DEADBAND: deadband_q <= cfg.data[DEADBAND_W-1:0];
				CFG_COEF:     coef_q     <= cfg.data[COEF_W-1:0];
				default:      ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		step.ready = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		mul_frac   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				step.ready = 1'b1;
				if (step.valid)
					state_d = step.enabled ? ST_ERR : ST_FIN;
			end
			ST_ERR: state_d = ST_DB;
			ST_DB:  state_d = ST_MP;
			ST_MP: begin
				mul_a   = MUL_W'(kp_q);
				mul_b   = MUL_W'(err_q);
				state_d = ST_MI;
			end
			ST_MI: begin
				mul_a   = MUL_W'(ki_q);
				mul_b   = MUL_W'(err_q);
				state_d = ST_MC1;
			end
			ST_MC1: begin
				mul_a    = $signed(MUL_W'(cw_q));
				mul_b    = MUL_W'(raw_q);
				mul_frac = 1'b0;
				state_d  = ST_MC2;
			end
			ST_MC2: begin
				mul_a    = $signed(MUL_W'(COEF_ONE - cw_q));
				mul_b    = MUL_W'(filt_q);
				mul_frac = 1'b0;
				state_d  = ST_MFF;
			end
			ST_MFF: begin
				mul_a   = MUL_W'(kff_q);
				mul_b   = MUL_W'(tgt_q);
				state_d = ST_MD;
			end
			ST_MD: begin
				mul_a   = MUL_W'(kd_q);
				mul_b   = MUL_W'(filt_q);
				state_d = ST_DW;
			end
			ST_DW:  state_d = ST_SUM;
			ST_SUM: state_d = ST_FIN;
			ST_FIN: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// shared multiplier, product registered
	always_ff @(posedge clk) begin
		prod_q      <= mul_a * mul_b;
		prod_frac_q <= mul_frac;
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q  <= '0;
			filt_q <= '0;
			prev_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && !step.enabled) begin
						int_q  <= '0;
						filt_q <= '0;
						prev_q <= '0;
					end
				end
				ST_MC1: int_q <= sat32(PROD_W'(int_q) + PROD_W'(term));
				ST_MC2: int_q <= clamp_ordered(int_q, half_q, imin_q);
				ST_MFF: filt_q <= sat32(PROD_W'(slope_q) + PROD_W'(term));
				ST_SUM: prev_q <= err_q;
				default: ;
			endcase
		end
	end

	// step datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				tgt_q   <= step.target;
				fb_q    <= step.feedback;
				err_q   <= '0;
				drive_q <= '0;
			end
			ST_ERR: err_q <= sat32(PROD_W'(tgt_q) - PROD_W'(fb_q));
			ST_DB: begin
				if (abs_err < {1'b0, deadband_q})
					err_q <= '0;
				half_q <= half_c;
				imin_q <= (half_c == DATA_MIN) ? DATA_MAX : -half_c;
			end
			ST_MP: begin
				raw_q <= sat32(PROD_W'(err_q) - PROD_W'(prev_q));
				cw_q  <= (coef_q > COEF_ONE) ? COEF_ONE : coef_q;
			end
			ST_MI:  acc_q   <= ACC_W'(term);
			ST_MC2: slope_q <= term;
			ST_MFF: acc_q   <= acc_q + ACC_W'(int_q);
			ST_MD:  acc_q   <= acc_q + ACC_W'(term);
			ST_DW:  acc_q   <= acc_q + ACC_W'(term);
			ST_SUM: drive_q <= clamp_ordered(sat32(PROD_W'(acc_q)), out_max_q, out_min_q);
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (out_load)
			out_vld_q <= 1'b1;
		else if (result.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_drive_q <= drive_q;
			out_err_q   <= err_q;
		end
	end

	assign result.valid     = out_vld_q;
	assign result.drive     = out_drive_q;
	assign result.error_now = out_err_q;

	// checks
	a_disable_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !step.enabled) |=> (int_q == '0 && filt_q == '0 && prev_q == '0))
		else $error("disabled step left loop state");

	a_int_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MFF && half_q >= imin_q) |-> (int_q <= half_q && int_q >= imin_q))
		else $error("integral outside its clamp");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside final state");

endmodule
`default_nettype wire
